/* hw/rtl/cpp_pkg.sv */
// Shared types and constants for the circle pixel plotter.
// Payload structs, command codes and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps

package cpp_pkg;

    localparam int COLUMNS_PER_CHIP = 64;
    localparam int PAGES            = 8;
    localparam int ROWS             = 8 * PAGES;
    localparam int STORE_DEPTH      = 2 * COLUMNS_PER_CHIP * PAGES;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);
    localparam int COL_W            = $clog2(COLUMNS_PER_CHIP);
    localparam int PAGE_W           = $clog2(PAGES);
    localparam int RADIUS_W         = 3;
    localparam int MAX_GROUPS       = 6;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd2;

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_DRAW   = 2'd2,
        CMD_ERASE  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] x;
        logic [7:0] y;
    } t_in;

    typedef struct packed {
        logic       chip;
        logic [5:0] column;
        logic [2:0] page;
        logic [7:0] data;
        logic       valid_res;
        logic       last;
    } t_out;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic rd;
        logic wr;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_done;
        logic out_free;
        logic plot_last;
    } t_dp_status;

endpackage

/* hw/rtl/cpp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module cpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/cpp_ctrl.sv */
// Controller for the circle pixel plotter: clear sweep, accept, read, write.
// Depends on cpp_pkg.
`timescale 1ns / 1ps

module cpp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cpp_pkg::t_dp_status i_status,
    output cpp_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WRITE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    logic   w_accept;

    assign w_accept = i_in_valid && r_in_ready;

    always_comb begin
        n_state    = r_state;
        n_in_ready = r_in_ready;
        o_cmd      = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clear_done) begin
                    n_state    = S_IDLE;
                    n_in_ready = 1'b1;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                    n_in_ready = 1'b0;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WRITE;
            end
            S_WRITE: begin
                if (i_status.out_free) begin
                    o_cmd.wr = 1'b1;
                    if (i_status.plot_last) begin
                        n_state    = S_IDLE;
                        n_in_ready = 1'b1;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

/* hw/rtl/cpp_datapath.sv */
// Datapath for the circle pixel plotter: walk registers, point generation,
// frame store read-modify-write and output register.
// Depends on cpp_pkg and cpp_ram.
`timescale 1ns / 1ps

module cpp_datapath #(
    parameter int MAX_RADIUS = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cpp_pkg::t_ctrl_cmd                  i_cmd,
    output cpp_pkg::t_dp_status                 o_status,
    input  cpp_pkg::t_in                        i_in,
    input  logic                                i_cfg_we,
    input  logic [cpp_pkg::RADIUS_W-1:0]        i_cfg_wdata,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output cpp_pkg::t_out                       o_out
);

    localparam logic [3:0] MAX_R = 4'(MAX_RADIUS);

    logic [cpp_pkg::RADIUS_W-1:0] r_radius;
    logic [cpp_pkg::ADDR_W-1:0]   r_clr_addr;

    logic [7:0]        r_cx, r_cy;
    logic              r_erase, r_circle;
    logic signed [5:0] r_wr, r_wo;
    logic signed [7:0] r_re, r_xc, r_yc;
    logic [2:0]        r_oct;
    logic [2:0]        r_grp;

    logic                       r_st_valid, r_st_last, r_st_chip;
    logic [cpp_pkg::COL_W-1:0]  r_st_col;
    logic [cpp_pkg::PAGE_W-1:0] r_st_page;
    logic [7:0]                 r_st_mask;

    cpp_pkg::t_out r_out;
    logic          r_out_valid;

    logic [3:0]        w_r0;
    logic signed [5:0] w_wo_n, w_wr_n;
    logic signed [7:0] w_re1, w_re_n, w_xc_n, w_yc_n;
    logic signed [9:0] w_err2;
    logic              w_step_down, w_final_group;
    logic [7:0]        w_a, w_b, w_px, w_py;
    logic              w_chip, w_pt_valid, w_pt_last;
    logic [cpp_pkg::ADDR_W-1:0] w_raddr, w_st_addr, w_waddr;
    logic [7:0]        w_rdata, w_new_byte, w_wdata;
    logic              w_we;

    // Saturate the configured radius
    assign w_r0 = ({1'b0, r_radius} > MAX_R) ? MAX_R : {1'b0, r_radius};

    // Midpoint walk step
    assign w_wo_n      = r_wo + 6'sd1;
    assign w_re1       = r_re + r_yc;
    assign w_yc_n      = r_yc + 8'sd2;
    assign w_err2      = {w_re1[7], w_re1, 1'b0} + {{2{r_xc[7]}}, r_xc};
    assign w_step_down = !w_err2[9] && (w_err2 != 10'd0);
    assign w_wr_n      = w_step_down ? r_wr - 6'sd1 : r_wr;
    assign w_re_n      = w_step_down ? w_re1 + r_xc : w_re1;
    assign w_xc_n      = w_step_down ? r_xc + 8'sd2 : r_xc;
    assign w_final_group = (w_wr_n < w_wo_n) || (r_grp == 3'(cpp_pkg::MAX_GROUPS - 1));

    // Octant point: swap offsets on the upper four, negate per octant
    always_comb begin
        if (r_circle) begin
            w_a = r_oct[2] ? {2'b00, r_wo} : {2'b00, r_wr};
            w_b = r_oct[2] ? {2'b00, r_wr} : {2'b00, r_wo};
        end else begin
            w_a = 8'd0;
            w_b = 8'd0;
        end
        w_px = (r_oct[1] ^ r_oct[0]) ? r_cx - w_a : r_cx + w_a;
        w_py = r_oct[1] ? r_cy - w_b : r_cy + w_b;
    end

    assign w_chip     = (w_px >= 8'(cpp_pkg::COLUMNS_PER_CHIP));
    assign w_pt_valid = (w_py < 8'(cpp_pkg::ROWS));
    assign w_pt_last  = !r_circle || (w_final_group && (r_oct == 3'd7));
    assign w_raddr    = {w_chip, w_px[cpp_pkg::COL_W-1:0], w_py[cpp_pkg::PAGE_W+2:3]};
    assign w_st_addr  = {r_st_chip, r_st_col, r_st_page};

    assign w_new_byte = r_erase ? (w_rdata & ~r_st_mask) : (w_rdata | r_st_mask);
    assign w_we       = i_cmd.clr_step || (i_cmd.wr && r_st_valid);
    assign w_waddr    = i_cmd.clr_step ? r_clr_addr : w_st_addr;
    assign w_wdata    = i_cmd.clr_step ? 8'd0 : w_new_byte;

    cpp_ram #(
        .WIDTH (8),
        .DEPTH (cpp_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= cpp_pkg::RADIUS_RESET;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_circle    <= 1'b0;
            r_erase     <= 1'b0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_wr        <= '0;
            r_wo        <= '0;
            r_re        <= '0;
            r_xc        <= '0;
            r_yc        <= '0;
            r_oct       <= '0;
            r_grp       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load) begin
                r_cx     <= i_in.x;
                r_cy     <= i_in.y;
                r_circle <= (i_in.cmd == cpp_pkg::CMD_DRAW) ||
                            (i_in.cmd == cpp_pkg::CMD_ERASE);
                r_erase  <= (i_in.cmd == cpp_pkg::CMD_CLEAR) ||
                            (i_in.cmd == cpp_pkg::CMD_ERASE);
                r_wr     <= {2'b00, w_r0};
                r_wo     <= '0;
                r_re     <= '0;
                r_xc     <= 8'sd1 - {3'b000, w_r0, 1'b0};
                r_yc     <= 8'sd1;
                r_oct    <= '0;
                r_grp    <= '0;
            end
            if (i_cmd.wr && r_circle) begin
                r_oct <= r_oct + 1'b1;
                if (r_oct == 3'd7) begin
                    r_wr  <= w_wr_n;
                    r_wo  <= w_wo_n;
                    r_re  <= w_re_n;
                    r_xc  <= w_xc_n;
                    r_yc  <= w_yc_n;
                    r_grp <= r_grp + 1'b1;
                end
            end
            // Hold the result until transferred
            if (i_cmd.wr) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_st_valid <= w_pt_valid;
            r_st_last  <= w_pt_last;
            r_st_chip  <= w_chip;
            r_st_col   <= w_px[cpp_pkg::COL_W-1:0];
            r_st_page  <= w_py[cpp_pkg::PAGE_W+2:3];
            r_st_mask  <= 8'b1 << w_py[2:0];
        end
        if (i_cmd.wr) begin
            r_out.chip      <= r_st_valid & r_st_chip;
            r_out.column    <= r_st_valid ? r_st_col : '0;
            r_out.page      <= r_st_valid ? r_st_page : '0;
            r_out.data      <= r_st_valid ? w_new_byte : 8'd0;
            r_out.valid_res <= r_st_valid;
            r_out.last      <= r_st_last;
        end
    end

    assign o_status.clear_done = &r_clr_addr;
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.plot_last  = r_st_last;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* hw/rtl/circle_pixel_plotter.sv */
// Circle pixel plotter: one-bit-per-pixel shadow store for a two-chip
// 128x64 page display, with pixel set/clear and midpoint circle draw/erase.
// Input item i_in (cmd, x, y) transfers on i_in_valid && o_in_ready.
// Each plotted point gives one result on o_out, transferred on
// o_out_valid && i_out_ready; last marks the final result of an item.
// Points with a row outside the store give valid_res 0 and are not stored.
// i_cfg_we writes the circle radius (3 bits, saturated at MAX_RADIUS).
// Every plot is a read-modify-write of one store byte, split into
// a read cycle and a modify/write cycle on the store RAM.
// A pixel item plots one point; a circle plots eight per walk group,
// groups being 1 to 6 walk steps (radius 2: 2 groups). o_in_ready is
// low from an item's transfer until its last plot is written, and the
// first result is registered by the write of its first plot.
// The result register holds its item while the receiver stalls; the
// write cycle of the next plot waits until that register is free.
// After reset the store is cleared by a sweep over all 1024 bytes, one byte a
// cycle, with o_in_ready low; configuration writes are taken throughout.
// Reset restores the radius to 2.
`timescale 1ns / 1ps

module circle_pixel_plotter #(
    parameter int MAX_RADIUS = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  cpp_pkg::t_in                 i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output cpp_pkg::t_out                o_out,
    input  logic                         i_cfg_we,
    input  logic [cpp_pkg::RADIUS_W-1:0] i_cfg_wdata
);

    cpp_pkg::t_ctrl_cmd  w_cmd;
    cpp_pkg::t_dp_status w_status;

    cpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cpp_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* verif/tb_top.sv */
// Testbench for circle_pixel_plotter: a scoreboard keeps its own frame store and circle walk,
// and checks each plot transfer in order against the expected result.
// Depends on cpp_pkg and circle_pixel_plotter.
`timescale 1ns / 1ps

module tb_top;
    import cpp_pkg::*;

    localparam int RADIUS_LIMIT    = 7;
    localparam int PLOTS_PER_ITEM  = 8 * MAX_GROUPS;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASES          = 6;
    localparam int PHASE_ITEMS     = 17;

    class plot_scoreboard;
        logic [7:0]          shadow [STORE_DEPTH];
        logic [RADIUS_W-1:0] radius;
        t_out                expected_plots [$];
        int                  failures;

        function new();
            foreach (shadow[i]) shadow[i] = 8'h00;
            radius   = RADIUS_RESET;
            failures = 0;
        endfunction

        function void set_radius(logic [RADIUS_W-1:0] value);
            radius = value;
        endfunction

        function int outstanding();
            return expected_plots.size();
        endfunction

        function void plot(logic [7:0] px, logic [7:0] py, bit erase, bit is_last);
            t_out       res;
            int         byte_addr;
            logic [7:0] mask;
            res      = '0;
            res.last = is_last;
            if (py < ROWS) begin
                res.chip   = (px >= COLUMNS_PER_CHIP);
                res.column = 6'(px % COLUMNS_PER_CHIP);
                res.page   = 3'(py / 8);
                byte_addr  = (int'(res.chip) * COLUMNS_PER_CHIP + int'(res.column)) * PAGES
                             + int'(res.page);
                mask = 8'(1 << (py % 8));
                if (erase) begin
                    shadow[byte_addr] = shadow[byte_addr] & ~mask;
                end else begin
                    shadow[byte_addr] = shadow[byte_addr] | mask;
                end
                res.data      = shadow[byte_addr];
                res.valid_res = 1'b1;
            end
            expected_plots.push_back(res);
        endfunction

        function void walk_circle(logic [7:0] cx, logic [7:0] cy, bit erase);
            int         rad;
            int         offset;
            int         err;
            int         x_step;
            int         y_step;
            int         count;
            int         k;
            bit         final_group;
            logic [7:0] dr;
            logic [7:0] doff;
            logic [7:0] px [8];
            logic [7:0] py [8];
            rad    = (radius > RADIUS_LIMIT) ? RADIUS_LIMIT : int'(radius);
            offset = 0;
            err    = 0;
            x_step = 1 - 2 * rad;
            y_step = 1;
            count  = 0;
            while (rad >= offset && count + 8 <= PLOTS_PER_ITEM) begin
                dr    = 8'(rad);
                doff  = 8'(offset);
                px[0] = cx + dr;   py[0] = cy + doff;
                px[1] = cx - dr;   py[1] = cy + doff;
                px[2] = cx - dr;   py[2] = cy - doff;
                px[3] = cx + dr;   py[3] = cy - doff;
                px[4] = cx + doff; py[4] = cy + dr;
                px[5] = cx - doff; py[5] = cy + dr;
                px[6] = cx - doff; py[6] = cy - dr;
                px[7] = cx + doff; py[7] = cy - dr;
                offset++;
                err    += y_step;
                y_step += 2;
                if (2 * err + x_step > 0) begin
                    rad--;
                    err    += x_step;
                    x_step += 2;
                end
                final_group = (rad < offset) || (count + 16 > PLOTS_PER_ITEM);
                for (k = 0; k < 8; k++) begin
                    plot(px[k], py[k], erase, final_group && k == 7);
                    count++;
                end
            end
        endfunction

        function void note_item(t_in item);
            case (item.cmd)
                CMD_SET:   plot(item.x, item.y, 1'b0, 1'b1);
                CMD_CLEAR: plot(item.x, item.y, 1'b1, 1'b1);
                CMD_DRAW:  walk_circle(item.x, item.y, 1'b0);
                CMD_ERASE: walk_circle(item.x, item.y, 1'b1);
                default:   ;
            endcase
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_plot(t_out got);
            t_out want;
            if (expected_plots.size() == 0) begin
                $error("unexpected plot transfer: chip %0d column %0d page %0d data 0x%0h",
                       got.chip, got.column, got.page, got.data);
                failures++;
                return;
            end
            want = expected_plots.pop_front();
            compare("chip", 8'(want.chip), 8'(got.chip));
            compare("column", 8'(want.column), 8'(got.column));
            compare("page", 8'(want.page), 8'(got.page));
            compare("data", want.data, got.data);
            compare("valid_res", 8'(want.valid_res), 8'(got.valid_res));
            compare("last", 8'(want.last), 8'(got.last));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in                 i_in;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out                o_out;
    logic                i_cfg_we;
    logic [RADIUS_W-1:0] i_cfg_wdata;

    bit tx_idle_en;
    bit rx_idle_en;
    bit rx_hold_req;

    plot_scoreboard sb = new();

    circle_pixel_plotter #(
        .MAX_RADIUS (RADIUS_LIMIT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_in make_item(t_cmd cmd, int x, int y);
        t_in item;
        item.cmd = cmd;
        item.x   = 8'(x);
        item.y   = 8'(y);
        return item;
    endfunction

    function automatic t_in random_item();
        t_in item;
        item.cmd = t_cmd'($urandom_range(0, 3));
        item.x   = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(52, 76)) : 8'($urandom);
        item.y   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 71));
        return item;
    endfunction

    task automatic offer(t_in item);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_item(item);
    endtask

    // drop valid and hold until every expected plot has come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [RADIUS_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_radius(value);
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready === 1'b1) sb.check_plot(o_out);
        end
    end

    initial begin
        #5_000_000;
        $display("circle_pixel_plotter verification failed");
        $finish;
    end

    initial begin
        int phase;
        int n;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        rx_hold_req = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset radius: pixels, store edges, rows off the store, wrapping circles
        offer(make_item(CMD_SET, 0, 0));
        offer(make_item(CMD_SET, 0, 1));
        offer(make_item(CMD_SET, 255, 63));
        offer(make_item(CMD_CLEAR, 0, 0));
        offer(make_item(CMD_SET, 63, 64));
        offer(make_item(CMD_SET, 64, 255));
        offer(make_item(CMD_CLEAR, 127, 7));
        offer(make_item(CMD_DRAW, 10, 10));
        offer(make_item(CMD_ERASE, 10, 10));
        offer(make_item(CMD_DRAW, 0, 0));
        offer(make_item(CMD_DRAW, 127, 62));
        offer(make_item(CMD_DRAW, 64, 4));

        // zero radius plots the centre eight times
        drain();
        write_radius(3'd0);
        offer(make_item(CMD_DRAW, 30, 30));
        offer(make_item(CMD_ERASE, 30, 30));

        drain();
        write_radius(3'd7);
        offer(make_item(CMD_DRAW, 60, 32));
        offer(make_item(CMD_DRAW, 250, 250));
        offer(make_item(CMD_ERASE, 60, 32));
        offer(make_item(CMD_DRAW, 63, 3));

        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0:       write_radius(3'd0);
                1:       write_radius(3'd7);
                default: write_radius(RADIUS_W'($urandom_range(0, 7)));
            endcase
            if (phase == 2) begin
                tx_idle_en  = 1'b0;
                rx_hold_req = 1'b1;
            end else if (phase == PHASES - 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end else begin
                tx_idle_en = 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == PHASE_ITEMS / 2) drain();
                offer(random_item());
            end
        end

        drain();
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("circle_pixel_plotter verification clean");
        end else begin
            $display("circle_pixel_plotter verification failed");
        end
        $finish;
    end

endmodule
